// ===== rtl/cau_pkg.sv =====
package cau_pkg;

    // Largest accepted cursor width or height in pixels.
    localparam int unsigned MAX_DIMENSION = 512;

    // Field widths fixed by the item format.
    localparam int unsigned DIM_W    = 10;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned BYTES_W  = 24;
    localparam int unsigned STRIDE_W = 12;
    localparam int unsigned AREA_W   = 2 * DIM_W;

    // Reset value of the shape size limit register.
    localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 24'h100000;

    // Item and result kinds.
    localparam logic OP_HEADER   = 1'b0;
    localparam logic OP_PIXEL    = 1'b1;
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // Request from the sequencer to the shared divider.
    typedef struct packed {
        logic              start;
        logic [CHAN_W-1:0] chan;
        logic [CHAN_W-1:0] alpha;
    } t_div_req;

    // Answer from the shared divider.
    typedef struct packed {
        logic              done;
        logic [CHAN_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/cau_div.sv =====
// Shared unpremultiply divider: (chan*255 + alpha/2) / alpha, saturated at 255,
// zero for zero alpha. One quotient bit is found per cycle after a load cycle.
module cau_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cau_pkg::t_div_req i_req,
    output cau_pkg::t_div_rsp o_rsp
);
    import cau_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [2:0]          r_cnt;
    logic [CHAN_W-1:0]   r_rem;
    logic [CHAN_W-1:0]   r_low;
    logic [CHAN_W-1:0]   r_quo;
    logic [CHAN_W-1:0]   r_div;

    logic [2*CHAN_W-1:0] num;
    logic                sat;
    logic [CHAN_W:0]     trial;
    logic                ge;
    logic [CHAN_W:0]     diff;

    // Dividend and the check for a quotient that does not fit in eight bits.
    assign num = ({i_req.chan, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, i_req.chan})
               + {{(CHAN_W+1){1'b0}}, i_req.alpha[CHAN_W-1:1]};
    assign sat = num >= {i_req.alpha, {CHAN_W{1'b0}}};

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign trial = {r_rem, r_low[CHAN_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                if (i_req.alpha == '0) begin
                    r_quo  <= '0;
                    r_done <= 1'b1;
                end else if (sat) begin
                    r_quo  <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= num[2*CHAN_W-1:CHAN_W];
                    r_low  <= num[CHAN_W-1:0];
                    r_div  <= i_req.alpha;
                    r_quo  <= '0;
                    r_cnt  <= 3'd7;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
                r_low <= {r_low[CHAN_W-2:0], 1'b0};
                r_quo <= {r_quo[CHAN_W-2:0], ge};
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

    // The remainder stays below the divisor between steps.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_div)
        else $error("divider remainder reached the divisor");

    // Completion is never reported together with an ongoing division.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    // A zero-alpha request answers zero on the next cycle.
    a_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && !r_busy && i_req.alpha == '0) |=> (r_done && r_quo == '0))
        else $error("zero alpha did not give zero");

endmodule

// ===== rtl/cursor_argb_unpremultiply_unit.sv =====
// Cursor shape unpremultiplier, premultiplied ARGB32 in, straight-alpha BGRA out.
// Input channel: i_valid with o_stall; a transfer happens when i_valid is high
// and o_stall is low. A header item (i_op 0) opens a shape, pixel items (i_op 1)
// follow in row-major order. The block takes one item at a time and holds
// o_stall high while that item is worked on.
// Output channel: o_valid with i_stall; every header gives one status result,
// every pixel of an accepted shape gives one converted pixel, last one flagged.
// Pixels with no open shape are taken and dropped with no result.
// A header passes through a check state and then a done state, from which its
// result is loaded into the output register. A pixel runs its three color
// channels one after another through one shared divider that finds one
// quotient bit per cycle, or skips those steps when alpha is 0 or the result
// saturates. The next item can be taken in the cycle after the result is loaded.
// The result sits in an output register, so the next item is taken while it
// waits; a finished item waits only if the output register is still full
// under i_stall. Synchronous reset clears the open shape, the counters and the
// output valid, and sets the size limit to 1048576 bytes. Configuration writes
// are always taken (o_cfg_ready is high) and belong to idle periods.
module cursor_argb_unpremultiply_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [cau_pkg::DIM_W-1:0]   i_shape_width,
    input  logic [cau_pkg::DIM_W-1:0]   i_shape_height,
    input  logic [cau_pkg::DIM_W-1:0]   i_hot_x,
    input  logic [cau_pkg::DIM_W-1:0]   i_hot_y,
    input  logic [31:0]                 i_argb_pixel,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_result_kind,
    output logic                        o_shape_accepted,
    output logic [cau_pkg::STRIDE_W-1:0] o_row_stride,
    output logic [cau_pkg::CHAN_W-1:0]  o_out_blue,
    output logic [cau_pkg::CHAN_W-1:0]  o_out_green,
    output logic [cau_pkg::CHAN_W-1:0]  o_out_red,
    output logic [cau_pkg::CHAN_W-1:0]  o_out_alpha,
    output logic                        o_last_pixel,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cau_pkg::BYTES_W-1:0] i_cfg_data
);
    import cau_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HDR  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    localparam logic [DIM_W:0] MAX_DIM = (DIM_W+1)'(MAX_DIMENSION);

    logic [1:0]          r_state;
    logic [1:0]          r_ch;
    logic                r_issue;
    logic [BYTES_W-1:0]  r_max_bytes;

    logic                r_frame_open;
    logic [DIM_W-1:0]    r_frame_width;
    logic [DIM_W-1:0]    r_frame_height;
    logic [DIM_W-1:0]    r_col;
    logic [DIM_W-1:0]    r_row;

    logic [DIM_W-1:0]    r_hdr_w;
    logic [DIM_W-1:0]    r_hdr_h;
    logic                r_hdr_basic;
    logic [AREA_W-1:0]   r_area;

    logic [CHAN_W-1:0]   r_alpha;
    logic [CHAN_W-1:0]   r_pix_b;
    logic [CHAN_W-1:0]   r_pix_g;
    logic [CHAN_W-1:0]   r_pix_r;
    logic                r_last;

    logic                r_res_kind;
    logic                r_res_acc;
    logic [STRIDE_W-1:0] r_res_stride;
    logic [CHAN_W-1:0]   r_res_b;
    logic [CHAN_W-1:0]   r_res_g;
    logic [CHAN_W-1:0]   r_res_r;

    logic                r_out_valid;
    logic                r_out_kind;
    logic                r_out_acc;
    logic [STRIDE_W-1:0] r_out_stride;
    logic [CHAN_W-1:0]   r_out_b;
    logic [CHAN_W-1:0]   r_out_g;
    logic [CHAN_W-1:0]   r_out_r;
    logic [CHAN_W-1:0]   r_out_a;
    logic                r_out_last;

    logic                in_xfer;
    logic                out_xfer;
    logic                out_free;
    logic                end_row;
    logic                last_pix;
    logic                basic_ok;
    logic                hdr_ok;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Position of the incoming pixel within the open shape.
    assign end_row  = ({1'b0, r_col} + 1'b1) >= {1'b0, r_frame_width};
    assign last_pix = end_row && (({1'b0, r_row} + 1'b1) >= {1'b0, r_frame_height});

    // Size and hotspot checks that need no multiplication.
    assign basic_ok = (i_shape_width != '0) && (i_shape_height != '0)
                   && ({1'b0, i_shape_width} <= MAX_DIM)
                   && ({1'b0, i_shape_height} <= MAX_DIM)
                   && (i_hot_x < i_shape_width) && (i_hot_y < i_shape_height);

    // Byte size check on the registered width times height.
    assign hdr_ok = r_hdr_basic
                 && ({{(BYTES_W-AREA_W-2){1'b0}}, r_area, 2'b00} <= r_max_bytes);

    // Divider request: one colour channel at a time.
    always_comb begin
        div_req.start = (r_state == S_DIV) && r_issue;
        div_req.alpha = r_alpha;
        case (r_ch)
            CH_BLUE:  div_req.chan = r_pix_b;
            CH_GREEN: div_req.chan = r_pix_g;
            CH_RED:   div_req.chan = r_pix_r;
            default:  div_req.chan = '0;
        endcase
    end

    cau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RESET;
        end else if (i_cfg_valid) begin
            r_max_bytes <= i_cfg_data;
        end
    end

    // Sequencer, shape state and result staging.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_issue        <= 1'b0;
            r_ch           <= CH_BLUE;
            r_frame_open   <= 1'b0;
            r_frame_width  <= '0;
            r_frame_height <= '0;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_op == OP_HEADER) begin
                            r_hdr_w     <= i_shape_width;
                            r_hdr_h     <= i_shape_height;
                            r_hdr_basic <= basic_ok;
                            r_area      <= AREA_W'(i_shape_width) * AREA_W'(i_shape_height);
                            r_state     <= S_HDR;
                        end else if (r_frame_open) begin
                            r_alpha <= i_argb_pixel[31:24];
                            r_pix_r <= i_argb_pixel[23:16];
                            r_pix_g <= i_argb_pixel[15:8];
                            r_pix_b <= i_argb_pixel[7:0];
                            r_last  <= last_pix;
                            if (last_pix) begin
                                r_frame_open <= 1'b0;
                                r_col        <= '0;
                                r_row        <= '0;
                            end else if (end_row) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                            r_ch    <= CH_BLUE;
                            r_issue <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_HDR: begin
                    r_frame_open <= hdr_ok;
                    r_col        <= '0;
                    r_row        <= '0;
                    r_res_kind   <= KIND_HEADER;
                    r_res_acc    <= hdr_ok;
                    r_res_b      <= '0;
                    r_res_g      <= '0;
                    r_res_r      <= '0;
                    r_last       <= 1'b0;
                    r_alpha      <= '0;
                    if (hdr_ok) begin
                        r_frame_width  <= r_hdr_w;
                        r_frame_height <= r_hdr_h;
                        r_res_stride   <= {r_hdr_w[STRIDE_W-3:0], 2'b00};
                    end else begin
                        r_frame_width  <= '0;
                        r_frame_height <= '0;
                        r_res_stride   <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DIV: begin
                    r_issue <= 1'b0;
                    if (div_rsp.done) begin
                        case (r_ch)
                            CH_BLUE:  r_res_b <= div_rsp.quot;
                            CH_GREEN: r_res_g <= div_rsp.quot;
                            default:  r_res_r <= div_rsp.quot;
                        endcase
                        if (r_ch == CH_RED) begin
                            r_res_kind   <= KIND_PIXEL;
                            r_res_acc    <= 1'b0;
                            r_res_stride <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_issue <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: loaded from staging when free, cleared on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_kind   <= r_res_kind;
            r_out_acc    <= r_res_acc;
            r_out_stride <= r_res_stride;
            r_out_b      <= r_res_b;
            r_out_g      <= r_res_g;
            r_out_r      <= r_res_r;
            r_out_a      <= r_alpha;
            r_out_last   <= r_last;
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_result_kind    = r_out_kind;
    assign o_shape_accepted = r_out_acc;
    assign o_row_stride     = r_out_stride;
    assign o_out_blue       = r_out_b;
    assign o_out_green      = r_out_g;
    assign o_out_red        = r_out_r;
    assign o_out_alpha      = r_out_a;
    assign o_last_pixel     = r_out_last;
    assign o_cfg_ready      = 1'b1;

    // An open shape always has a legal size.
    a_open_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open |-> (r_frame_width != '0 && {1'b0, r_frame_width} <= MAX_DIM
                          && r_frame_height != '0 && {1'b0, r_frame_height} <= MAX_DIM))
        else $error("open shape with illegal size");

    // The divider answers only while a pixel is being converted.
    a_div_in_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider answer outside pixel conversion");

    // A converted pixel with zero alpha carries zero colour.
    a_zero_alpha_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_PIXEL && o_out_alpha == '0)
            |-> (o_out_blue == '0 && o_out_green == '0 && o_out_red == '0))
        else $error("zero alpha pixel with nonzero colour");

    // A rejected header leaves no shape open.
    a_reject_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR && !hdr_ok) |=> !r_frame_open)
        else $error("rejected header left a shape open");

endmodule

// ===== tb/cursor_argb_unpremultiply_checker.sv =====
// Watches the item, result and configuration channels of the unpremultiply
// unit, keeps its own copy of the shape state and predicts every result.
module cursor_argb_unpremultiply_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Item channel.
    input  logic                         i_item_valid,
    input  logic                         i_item_stall,
    input  logic                         i_op,
    input  logic [cau_pkg::DIM_W-1:0]    i_shape_width,
    input  logic [cau_pkg::DIM_W-1:0]    i_shape_height,
    input  logic [cau_pkg::DIM_W-1:0]    i_hot_x,
    input  logic [cau_pkg::DIM_W-1:0]    i_hot_y,
    input  logic [31:0]                  i_argb_pixel,
    // Result channel.
    input  logic                         i_res_valid,
    input  logic                         i_res_stall,
    input  logic                         i_result_kind,
    input  logic                         i_shape_accepted,
    input  logic [cau_pkg::STRIDE_W-1:0] i_row_stride,
    input  logic [cau_pkg::CHAN_W-1:0]   i_out_blue,
    input  logic [cau_pkg::CHAN_W-1:0]   i_out_green,
    input  logic [cau_pkg::CHAN_W-1:0]   i_out_red,
    input  logic [cau_pkg::CHAN_W-1:0]   i_out_alpha,
    input  logic                         i_last_pixel,
    // Size limit register write channel.
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [cau_pkg::BYTES_W-1:0]  i_cfg_data,
    // Status for the testbench top.
    output int                           o_fail_count,
    output int                           o_outstanding
);
    import cau_pkg::*;

    typedef struct packed {
        logic                kind;
        logic                accepted;
        logic [STRIDE_W-1:0] stride;
        logic [CHAN_W-1:0]   blue;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   alpha;
        logic                is_last;
    } t_shape_result;

    // Results still owed by the block, oldest first.
    t_shape_result expected_results[$];

    // Shadow copy of the block's shape state and size limit.
    logic [BYTES_W-1:0] size_limit = MAX_BYTES_RESET;
    logic               shape_open = 1'b0;
    logic [DIM_W-1:0]   shape_w    = '0;
    logic [DIM_W-1:0]   shape_h    = '0;
    logic [DIM_W-1:0]   col        = '0;
    logic [DIM_W-1:0]   row        = '0;

    int mismatch_count = 0;
    int outstanding    = 0;

    assign o_fail_count  = mismatch_count;
    assign o_outstanding = outstanding;

    // Straight-alpha value of one colour channel, rounded and saturated.
    function automatic logic [CHAN_W-1:0] straight_channel(input logic [CHAN_W-1:0] c,
                                                           input logic [CHAN_W-1:0] a);
        int unsigned q;
        if (a == '0) begin
            return '0;
        end
        q = (32'(c) * 32'd255 + 32'(a) / 32'd2) / 32'(a);
        return (q > 32'd255) ? 8'hff : q[CHAN_W-1:0];
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    endtask

    // Updates the shadow state for one accepted item and queues its result, if it has one.
    task automatic predict_shape_item();
        t_shape_result r;
        logic [31:0]   area;
        logic          ok;
        logic          end_row;
        logic          done;
        logic [7:0]    a;
        r = '0;
        if (i_op == OP_HEADER) begin
            area = 32'(i_shape_width) * 32'd4 * 32'(i_shape_height);
            ok = (i_shape_width != '0) && (i_shape_height != '0) &&
                 (32'(i_shape_width) <= MAX_DIMENSION) &&
                 (32'(i_shape_height) <= MAX_DIMENSION) &&
                 (i_hot_x < i_shape_width) && (i_hot_y < i_shape_height) &&
                 (area <= 32'(size_limit));
            shape_open = ok;
            col = '0;
            row = '0;
            r.kind = KIND_HEADER;
            if (ok) begin
                shape_w    = i_shape_width;
                shape_h    = i_shape_height;
                r.accepted = 1'b1;
                r.stride   = {i_shape_width, 2'b00};
            end else begin
                shape_w = '0;
                shape_h = '0;
            end
            expected_results.push_back(r);
        end else if (shape_open) begin
            a       = i_argb_pixel[31:24];
            end_row = (32'(col) + 32'd1 >= 32'(shape_w));
            done    = end_row && (32'(row) + 32'd1 >= 32'(shape_h));
            r.kind    = KIND_PIXEL;
            r.blue    = straight_channel(i_argb_pixel[7:0], a);
            r.green   = straight_channel(i_argb_pixel[15:8], a);
            r.red     = straight_channel(i_argb_pixel[23:16], a);
            r.alpha   = a;
            r.is_last = done;
            // Step through the shape in row-major order.
            if (done) begin
                shape_open = 1'b0;
                col = '0;
                row = '0;
            end else if (end_row) begin
                col = '0;
                row = row + 1'b1;
            end else begin
                col = col + 1'b1;
            end
            expected_results.push_back(r);
        end
        outstanding = expected_results.size();
    endtask

    // Compares one result transfer against the oldest expectation.
    task automatic check_shape_result();
        t_shape_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, kind", i_result_kind, 0);
            return;
        end
        want = expected_results.pop_front();
        outstanding = expected_results.size();
        if (i_result_kind !== want.kind)
            report_mismatch("result_kind", i_result_kind, want.kind);
        if (i_shape_accepted !== want.accepted)
            report_mismatch("shape_accepted", i_shape_accepted, want.accepted);
        if (i_row_stride !== want.stride)
            report_mismatch("row_stride", i_row_stride, want.stride);
        if (i_out_blue !== want.blue)
            report_mismatch("out_blue", i_out_blue, want.blue);
        if (i_out_green !== want.green)
            report_mismatch("out_green", i_out_green, want.green);
        if (i_out_red !== want.red)
            report_mismatch("out_red", i_out_red, want.red);
        if (i_out_alpha !== want.alpha)
            report_mismatch("out_alpha", i_out_alpha, want.alpha);
        if (i_last_pixel !== want.is_last)
            report_mismatch("last_pixel", i_last_pixel, want.is_last);
    endtask

    // Sample all three channels at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_limit = MAX_BYTES_RESET;
            shape_open = 1'b0;
            shape_w    = '0;
            shape_h    = '0;
            col        = '0;
            row        = '0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                check_shape_result();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                size_limit = i_cfg_data;
            end
            if (i_item_valid && !i_item_stall) begin
                predict_shape_item();
            end
        end
    end

endmodule

// ===== tb/cursor_argb_unpremultiply_unit_tb.sv =====
// Drives headers and pixels into the unpremultiply unit with random gaps and
// back-pressure; the checker beside the block predicts and compares.
module cursor_argb_unpremultiply_unit_tb;

    import cau_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_op;
    logic [DIM_W-1:0]    i_shape_width;
    logic [DIM_W-1:0]    i_shape_height;
    logic [DIM_W-1:0]    i_hot_x;
    logic [DIM_W-1:0]    i_hot_y;
    logic [31:0]         i_argb_pixel;
    logic                o_valid;
    logic                i_stall;
    logic                o_result_kind;
    logic                o_shape_accepted;
    logic [STRIDE_W-1:0] o_row_stride;
    logic [CHAN_W-1:0]   o_out_blue;
    logic [CHAN_W-1:0]   o_out_green;
    logic [CHAN_W-1:0]   o_out_red;
    logic [CHAN_W-1:0]   o_out_alpha;
    logic                o_last_pixel;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [BYTES_W-1:0]  i_cfg_data;

    int fail_count;
    int outstanding;

    // Stimulus bookkeeping.
    int unsigned        items_sent     = 0;
    logic [BYTES_W-1:0] size_limit_now = MAX_BYTES_RESET;
    bit                 calm           = 1'b0;
    int unsigned        hold_reqs      = 0;

    cursor_argb_unpremultiply_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_shape_width    (i_shape_width),
        .i_shape_height   (i_shape_height),
        .i_hot_x          (i_hot_x),
        .i_hot_y          (i_hot_y),
        .i_argb_pixel     (i_argb_pixel),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_shape_accepted (o_shape_accepted),
        .o_row_stride     (o_row_stride),
        .o_out_blue       (o_out_blue),
        .o_out_green      (o_out_green),
        .o_out_red        (o_out_red),
        .o_out_alpha      (o_out_alpha),
        .o_last_pixel     (o_last_pixel),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    cursor_argb_unpremultiply_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (i_valid),
        .i_item_stall     (o_stall),
        .i_op             (i_op),
        .i_shape_width    (i_shape_width),
        .i_shape_height   (i_shape_height),
        .i_hot_x          (i_hot_x),
        .i_hot_y          (i_hot_y),
        .i_argb_pixel     (i_argb_pixel),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_result_kind    (o_result_kind),
        .i_shape_accepted (o_shape_accepted),
        .i_row_stride     (o_row_stride),
        .i_out_blue       (o_out_blue),
        .i_out_green      (o_out_green),
        .i_out_red        (o_out_red),
        .i_out_alpha      (o_out_alpha),
        .i_last_pixel     (o_last_pixel),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    // Clock with a period of 8.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_idle();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end
        if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Premultiplied pixel, biased to alpha 0, alpha 255 and channels within alpha.
    function automatic logic [31:0] random_argb();
        int unsigned pick;
        logic [7:0]  a;
        logic [7:0]  chan [3];
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return $urandom;
        end
        a = (pick < 25) ? 8'h00 : (pick < 40) ? 8'hff : 8'($urandom_range(0, 255));
        foreach (chan[k]) begin
            chan[k] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, a));
        end
        return {a, chan[2], chan[1], chan[0]};
    endfunction

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int unsigned holds_served;
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned run_left;
        holds_served = 0;
        hold_left    = 0;
        stall_left   = 0;
        run_left     = 0;
        i_stall      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != holds_served) begin
                holds_served = hold_reqs;
                hold_left    = 300;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (calm) begin
                i_stall = 1'b0;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else if (run_left > 0) begin
                i_stall = 1'b0;
                run_left--;
            end else begin
                i_stall    = 1'b0;
                stall_left = pick_idle();
                run_left   = $urandom_range(1, 8);
            end
        end
    end

    // One item transfer, after a random gap; valid stays high into the next item.
    task automatic transfer_item(input logic op, input int unsigned w, input int unsigned h,
                                 input int unsigned hx, input int unsigned hy,
                                 input logic [31:0] argb, input bit counted);
        int unsigned gap;
        gap = calm ? 0 : pick_idle();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_op           = op;
        i_shape_width  = DIM_W'(w);
        i_shape_height = DIM_W'(h);
        i_hot_x        = DIM_W'(hx);
        i_hot_y        = DIM_W'(hy);
        i_argb_pixel   = argb;
        i_valid        = 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (counted) begin
            items_sent++;
        end
    endtask

    task automatic send_header(input int unsigned w, input int unsigned h,
                               input int unsigned hx, input int unsigned hy);
        transfer_item(OP_HEADER, w, h, hx, hy, $urandom, 1'b1);
    endtask

    task automatic send_pixel(input logic [31:0] argb, input bit counted);
        transfer_item(OP_PIXEL, $urandom, $urandom, $urandom, $urandom, argb, counted);
    endtask

    // Stop offering items and wait until every owed result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (outstanding == 0);
    endtask

    // Size limit write while idle; dropped pixels may still be in flight, so wait.
    task automatic write_size_limit(input logic [BYTES_W-1:0] limit);
        drain_results();
        repeat (40) @(negedge i_clk);
        i_cfg_data  = limit;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid    = 1'b0;
        size_limit_now = limit;
    endtask

    // One shape: mostly well formed, sometimes cut short, overrun or pure noise.
    task automatic random_shape();
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned overrun;
        bit          accepted;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            send_header($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
            repeat ($urandom_range(0, 2)) send_pixel(random_argb(), 1'b0);
            return;
        end
        if (pick < 15) begin
            w = $urandom_range(17, 64);
            h = 1;
        end else if (pick < 18) begin
            w = 1;
            h = $urandom_range(17, 48);
        end else if (pick < 30) begin
            w = $urandom_range(5, 16);
            h = $urandom_range(1, 4);
        end else begin
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 4);
        end
        send_header(w, h, $urandom_range(0, w - 1), $urandom_range(0, h - 1));
        accepted = (w * 4 * h <= 32'(size_limit_now));
        n        = w * h;
        overrun  = 0;
        pick     = $urandom_range(0, 99);
        if (!accepted) begin
            n = $urandom_range(0, 2);
        end else if (pick < 12) begin
            n = $urandom_range(0, n - 1);
        end else if (pick < 22) begin
            overrun = $urandom_range(1, 2);
        end
        repeat (n) send_pixel(random_argb(), accepted);
        repeat (overrun) send_pixel(random_argb(), 1'b0);
        if ($urandom_range(0, 29) == 0) begin
            drain_results();
        end
    endtask

    task automatic run_phase(input int unsigned budget);
        int unsigned target;
        target = items_sent + budget;
        while (items_sent < target) begin
            random_shape();
        end
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_op           = OP_HEADER;
        i_shape_width  = '0;
        i_shape_height = '0;
        i_hot_x        = '0;
        i_hot_y        = '0;
        i_argb_pixel   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pixel with no shape open is dropped.
        send_pixel(32'hffffffff, 1'b0);
        // Smallest shape, alpha zero, then a pixel past the end.
        send_header(1, 1, 0, 0);
        send_pixel(32'h00ffffff, 1'b1);
        send_pixel(32'h80402010, 1'b0);
        // Full alpha, saturation, tiny alpha and rounding.
        send_header(2, 2, 1, 1);
        send_pixel(32'hffffffff, 1'b1);
        send_pixel(32'h80ff4020, 1'b1);
        send_pixel(32'h01010000, 1'b1);
        send_pixel(32'h7f3f1f0f, 1'b1);
        // Rejected headers: zero size, oversize, all ones, hotspot on the edge.
        send_header(0, 1, 0, 0);
        send_pixel(32'hff000000, 1'b0);
        send_header(513, 1, 0, 0);
        send_header(1, 513, 0, 0);
        send_header(1023, 1023, 1023, 1023);
        send_header(3, 2, 3, 0);
        send_header(3, 2, 0, 2);
        // Widest row, abandoned by a new header.
        send_header(512, 1, 511, 0);
        send_pixel(32'h20101008, 1'b1);
        send_pixel(32'hc0c08000, 1'b1);
        send_header(2, 1, 1, 0);
        send_pixel(32'h40404040, 1'b1);
        // Largest shape exactly at the default limit, then a rejected header closes it.
        send_header(512, 512, 511, 511);
        send_pixel(32'h10ff00ff, 1'b1);
        send_header(2, 2, 2, 0);
        send_pixel(32'hffffffff, 1'b0);

        // Area check against a small limit: equal passes, larger fails.
        write_size_limit(24'd16);
        send_header(2, 2, 0, 0);
        repeat (4) send_pixel(random_argb(), 1'b1);
        send_header(3, 2, 0, 0);

        // Largest limit; the first stretch runs with no idling at all.
        write_size_limit(24'hffffff);
        calm = 1'b1;
        run_phase(80);
        calm = 1'b0;
        run_phase(120);

        write_size_limit(BYTES_W'($urandom_range(4, 400)));
        run_phase(150);

        // Nothing fits: every header is rejected.
        write_size_limit(24'd0);
        run_phase(40);

        // Back to the reset value; a long receiver hold-off fills the block.
        write_size_limit(MAX_BYTES_RESET);
        calm = 1'b1;
        hold_reqs++;
        send_header(4, 4, 2, 3);
        repeat (16) send_pixel(random_argb(), 1'b1);
        calm = 1'b0;
        run_phase(160);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a hang.
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
